/* hdl/frsu_pkg.sv */
// ----------------------------------------------------------------------------
// Float round and sign unit package
// Opcodes, float constants and fixed-point widths shared by the unit's modules.
// ----------------------------------------------------------------------------
package frsu_pkg;

  // Instruction codes carried in the input word's tuser field.
  typedef enum logic [3:0] {
    OP_ROUND     = 4'd0,
    OP_ROUNDEVEN = 4'd1,
    OP_TRUNC     = 4'd2,
    OP_FABS      = 4'd3,
    OP_SABS      = 4'd4,
    OP_FSIGN     = 4'd5,
    OP_SSIGN     = 4'd6,
    OP_FLOOR     = 4'd7,
    OP_CEIL      = 4'd8,
    OP_FRACT     = 4'd9
  } op_t;

  // Binary32 constants.
  localparam logic [31:0] F_ONE       = 32'h3F80_0000;
  localparam logic [31:0] F_MINUS_ONE = 32'hBF80_0000;
  localparam logic [31:0] F_QNAN      = 32'h7FC0_0000;
  localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;

  // The fract path works on a fixed-point value with FIX_W fraction bits.
  localparam int FIX_W = 48;
  localparam int D_W   = FIX_W + 1;
  localparam int POS_W = 6;

  // Exponent of a fixed-point value whose leading one is at bit zero.
  localparam logic [7:0] FIX_EXP_BASE = 8'(127 - FIX_W);

endpackage

/* hdl/frsu_norm.sv */
// ----------------------------------------------------------------------------
// Fract normalizer
// Two-step normalize and round-to-nearest-even of a positive fixed-point value
// below 1.0 into a binary32 word. The leading-one search is registered first.
// ----------------------------------------------------------------------------
module frsu_norm
  import frsu_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [D_W-1:0]   d,     // fixed point, FIX_W fraction bits, nonzero
  output logic [31:0]      word   // binary32 of the registered value
);

  logic [POS_W-1:0] p_next;
  logic [D_W-1:0]   dq;
  logic [POS_W-1:0] pq;
  logic [D_W-1:0]   a;
  logic [23:0]      mant;
  logic             guard;
  logic             sticky;
  logic [24:0]      mant_r;
  logic [7:0]       exp;

  // Leading-one position; the highest set bit wins.
  always_comb begin
    p_next = '0;
    for (int i = 0; i < D_W; i++) begin
      if (d[i]) p_next = POS_W'(i);
    end
  end

  // Value and its leading-one position move together.
  always_ff @(posedge clk) begin
    if (en) begin
      dq <= d;
      pq <= p_next;
    end
  end

  // Align the leading one to the top bit, then round to 24 bits.
  always_comb begin
    a      = dq << (POS_W'(FIX_W) - pq);
    mant   = a[D_W-1 -: 24];
    guard  = a[D_W-25];
    sticky = |a[D_W-26:0];
    mant_r = {1'b0, mant} + 25'(guard & (sticky | mant[0]));
    exp    = FIX_EXP_BASE + {2'b00, pq} + {7'd0, mant_r[24]};
    word   = {1'b0, exp, mant_r[24] ? 23'd0 : mant_r[22:0]};
  end

endmodule

/* hdl/float_round_sign_unit.sv */
// ----------------------------------------------------------------------------
// Float round and sign unit
// Executes one rounding or sign instruction on one 32-bit element per word.
//
//   channel  dir  tdata               tuser
//   s_*      in   [31:0] operand      [3:0] req_type
//   m_*      out  [31:0] result       [0]   unsupported
//
// Four register stages: input, operation, normalize, output. A new word is
// taken every cycle while the output register is empty or read.
// All stages advance together whenever the output register is empty or read,
// so a stall at m_tready holds the whole pipeline.
// Reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
module float_round_sign_unit
  import frsu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] operand
  input  logic [3:0]  s_tuser,   // [3:0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] result
  output logic [0:0]  m_tuser    // [0] unsupported
);

  logic           adv;
  logic           v1, v2, v3;
  logic [3:0]     op1;
  logic [31:0]    x1;
  logic [31:0]    res_next, res2, res3;
  logic           bad_next, bad2, bad3;
  logic           norm_next, norm2, norm3;
  logic [D_W-1:0] d_next, d2;
  logic [31:0]    norm_word;

  // Round to an integral value in the mode given by the opcode.
  function automatic logic [31:0] round_int(input logic [31:0] x, input op_t op);
    logic        s;
    logic [7:0]  be;
    logic [22:0] frac;
    logic [4:0]  nf;
    logic [23:0] m, mask, fr, ip, half;
    logic [24:0] ips;
    logic        up;
    logic [31:0] r;
    s    = x[31];
    be   = x[30:23];
    frac = x[22:0];
    nf   = 5'(8'd150 - be);
    m    = {1'b1, frac};
    mask = (24'd1 << nf) - 24'd1;
    fr   = m & mask;
    ip   = m & ~mask;
    half = 24'd1 << (nf - 5'd1);
    up   = 1'b0;
    ips  = '0;
    r    = x;
    if (be == 8'hFF) begin
      r = (frac != 23'd0) ? (x | QUIET_BIT) : x;
    end else if (be >= 8'd150 || (be == 8'd0 && frac == 23'd0)) begin
      r = x;
    end else if (be < 8'd127) begin
      // Magnitude below one: the result is zero or one, sign kept.
      case (op)
        OP_FLOOR:     up = s;
        OP_CEIL:      up = !s;
        OP_ROUND:     up = (be == 8'd126);
        OP_ROUNDEVEN: up = (be == 8'd126) && (frac != 23'd0);
        default:      up = 1'b0;
      endcase
      r = {s, up ? F_ONE[30:0] : 31'd0};
    end else if (fr == 24'd0) begin
      r = x;
    end else begin
      case (op)
        OP_FLOOR:     up = s;
        OP_CEIL:      up = !s;
        OP_ROUND:     up = (fr >= half);
        OP_ROUNDEVEN: up = (fr > half) || (fr == half && ip[nf]);
        default:      up = 1'b0;
      endcase
      ips = {1'b0, ip} + (up ? (25'd1 << nf) : 25'd0);
      if (ips[24]) r = {s, be + 8'd1, 23'd0};
      else         r = {s, be, ips[22:0]};
    end
    return r;
  endfunction

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= s_tvalid;
    end
    if (adv) begin
      op1 <= s_tuser;
      x1  <= s_tdata;
    end
  end

  // Operation decode; fract prepares a fixed-point value for the normalizer.
  always_comb begin
    logic        s;
    logic [7:0]  be, beff, nf;
    logic [22:0] frac;
    logic [23:0] sig, sigf;
    logic [71:0] fw;
    logic [FIX_W-1:0] f;
    s         = x1[31];
    be        = x1[30:23];
    frac      = x1[22:0];
    beff      = (be == 8'd0) ? 8'd1 : be;
    nf        = 8'd150 - beff;
    sig       = {be != 8'd0, frac};
    sigf      = (nf >= 8'd24) ? sig : (sig & ((24'd1 << nf[4:0]) - 24'd1));
    fw        = {sigf, 48'd0} >> nf;
    f         = fw[FIX_W-1:0];
    res_next  = '0;
    bad_next  = 1'b0;
    norm_next = 1'b0;
    d_next    = {1'b0, f};
    case (op1)
      OP_ROUND, OP_ROUNDEVEN, OP_TRUNC, OP_FLOOR, OP_CEIL: begin
        res_next = round_int(x1, op_t'(op1));
      end
      OP_FABS: begin
        res_next = {1'b0, x1[30:0]};
      end
      OP_SABS: begin
        res_next = s ? (~x1 + 32'd1) : x1;
      end
      OP_FSIGN: begin
        if ((be == 8'hFF && frac != 23'd0) || x1[30:0] == 31'd0) res_next = '0;
        else res_next = s ? F_MINUS_ONE : F_ONE;
      end
      OP_SSIGN: begin
        res_next = s ? 32'hFFFF_FFFF : ((x1 != 32'd0) ? 32'd1 : 32'd0);
      end
      OP_FRACT: begin
        if (be == 8'hFF) begin
          res_next = (frac != 23'd0) ? (x1 | QUIET_BIT) : F_QNAN;
        end else if (be >= 8'd150 || sigf == 24'd0) begin
          res_next = '0;
        end else if (!s) begin
          // Positive: the fraction bits themselves, exact.
          if (nf >= 8'd24) res_next = x1;
          else norm_next = 1'b1;
        end else if (nf > 8'(FIX_W)) begin
          // Negative with a fraction at or below half an ulp of one.
          res_next = F_ONE;
        end else begin
          norm_next = 1'b1;
          d_next    = (D_W'(1) << FIX_W) - {1'b0, f};
        end
      end
      default: begin
        bad_next = 1'b1;
      end
    endcase
  end

  // Operation register.
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
    if (adv) begin
      res2  <= res_next;
      bad2  <= bad_next;
      norm2 <= norm_next;
      d2    <= d_next;
    end
  end

  frsu_norm u_norm (
    .clk  (clk),
    .en   (adv),
    .d    (d2),
    .word (norm_word)
  );

  // Normalize stage, in step with the register inside the normalizer.
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
    if (adv) begin
      res3  <= res2;
      bad3  <= bad2;
      norm3 <= norm2;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= v3;
    end
    if (adv) begin
      m_tdata    <= norm3 ? norm_word : res3;
      m_tuser[0] <= bad3;
    end
  end

  // An unsupported opcode always returns zero.
  a_bad_zero : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == 32'd0)
    else $error("unsupported opcode returned a nonzero result");

  // A word in the input register reaches the operation register on advance.
  a_v_flow : assert property (@(posedge clk) disable iff (rst)
    adv && v1 |=> v2)
    else $error("word lost between input and operation stages");

  // A normalized fract result is positive, with an exponent no greater than one's.
  a_fract_range : assert property (@(posedge clk) disable iff (rst)
    v3 && norm3 |-> !norm_word[31] && norm_word[30:23] <= 8'd127)
    else $error("fract result out of range");

  // Unsupported and fract normalization never coincide.
  a_bad_norm : assert property (@(posedge clk) disable iff (rst)
    v2 && bad2 |-> !norm2)
    else $error("unsupported word marked for normalization");

endmodule
